### hdl/bcx_pkg.sv
package bcx_pkg;

  // fixed field widths of a request and a result
  localparam int VALID_W = 6;
  localparam int OFF_W   = 32;
  localparam int SLOPE_W = 16;
  localparam int RES_W   = 32;

  // one word adds at most +-63, which is held in 8 signed bits
  localparam int CTB_W = 8;

  // fixed-point positions: offset and result q.8, slope q.14
  localparam int Q_SH     = 8;
  localparam int ROUND_SH = 14;

  // slope of one in q1.14, used to pass non-negative sums through the multiplier
  localparam logic signed [SLOPE_W-1:0] UNIT_SLOPE = 16'sd16384;

  typedef struct packed {
    logic signed [CTB_W-1:0]   contrib;
    logic                      last;
    logic signed [OFF_W-1:0]   offset;
    logic signed [SLOPE_W-1:0] slope;
  } work_t;

  typedef struct packed {
    logic signed [RES_W-1:0] value;
    logic                    sat;
  } result_t;

endpackage

### hdl/bcx_queue.sv
module bcx_queue #(
  parameter int DEPTH  = 2,
  parameter int DATA_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] wdata_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic [DATA_W-1:0] rdata_o,
  output logic              empty_o
);

  // depth is a power of two of at least two, so the pointers wrap by themselves
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_q, rd_q;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    case ({do_push, do_pop})
      2'b10:   cnt_d = cnt_q + CNT_W'(1);
      2'b01:   cnt_d = cnt_q - CNT_W'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_q <= wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= rd_q + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

### hdl/bcx_front.sv
module bcx_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                             push_i,
  input  logic [WORD_BITS-1:0]             act_word_i,
  input  logic [WORD_BITS-1:0]             weight_word_i,
  input  logic [bcx_pkg::VALID_W-1:0]      valid_bits_i,
  input  logic                             last_word_i,
  input  logic signed [bcx_pkg::OFF_W-1:0] bn_offset_i,
  input  logic signed [bcx_pkg::SLOPE_W-1:0] prelu_slope_i,
  input  logic                             work_full_i,
  output logic                             work_push_o,
  output bcx_pkg::work_t                   work_o
);

  localparam int NBYTE = (WORD_BITS + 7) / 8;
  localparam int VC_W  = bcx_pkg::VALID_W + 1;
  localparam logic [VC_W-1:0] WB_LIM = VC_W'(WORD_BITS);

  logic [VC_W-1:0]      valid_c;
  logic [WORD_BITS-1:0] mask;
  logic [NBYTE*8-1:0]   diff_pad;
  logic [3:0]           byte_cnt [NBYTE];
  logic [VC_W-1:0]      pop_cnt;

  assign work_push_o = push_i && !work_full_i;

  // lengths beyond the word are taken as a full word
  always_comb begin
    valid_c = {1'b0, valid_bits_i};
    if (valid_c > WB_LIM) begin
      valid_c = WB_LIM;
    end
    for (int i = 0; i < WORD_BITS; i++) begin
      mask[i] = (VC_W'(i) < valid_c);
    end
  end

  assign diff_pad = (NBYTE*8)'((act_word_i ^ weight_word_i) & mask);

  // two-level popcount: per byte, then over the bytes
  always_comb begin
    for (int j = 0; j < NBYTE; j++) begin
      byte_cnt[j] = '0;
      for (int b = 0; b < 8; b++) begin
        byte_cnt[j] = byte_cnt[j] + 4'(diff_pad[j*8+b]);
      end
    end
    pop_cnt = '0;
    for (int j = 0; j < NBYTE; j++) begin
      pop_cnt = pop_cnt + VC_W'(byte_cnt[j]);
    end
  end

  always_comb begin
    work_o.contrib = $signed(bcx_pkg::CTB_W'(valid_c) - {pop_cnt, 1'b0});
    work_o.last    = last_word_i;
    work_o.offset  = bn_offset_i;
    work_o.slope   = prelu_slope_i;
  end

endmodule

### hdl/bcx_back.sv
module bcx_back #(
  parameter int ACC_BITS = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  bcx_pkg::work_t   work_i,
  input  logic             work_empty_i,
  output logic             work_pop_o,
  input  logic             res_full_i,
  output logic             res_push_o,
  output bcx_pkg::result_t res_o
);

  localparam int SUM_W  = ((ACC_BITS + bcx_pkg::Q_SH) > bcx_pkg::OFF_W ?
                           ACC_BITS + bcx_pkg::Q_SH : bcx_pkg::OFF_W) + 1;
  localparam int PROD_W = SUM_W + bcx_pkg::SLOPE_W;

  localparam logic signed [ACC_BITS:0] ACC_MAX = {2'b00, {(ACC_BITS-1){1'b1}}};
  localparam logic signed [ACC_BITS:0] ACC_MIN = {2'b11, {(ACC_BITS-1){1'b0}}};
  localparam logic signed [PROD_W:0] ROUND_HALF = (PROD_W+1)'(1) << (bcx_pkg::ROUND_SH - 1);
  localparam logic signed [PROD_W:0] RES_MAX =
    {{(PROD_W+2-bcx_pkg::RES_W){1'b0}}, {(bcx_pkg::RES_W-1){1'b1}}};
  localparam logic signed [PROD_W:0] RES_MIN =
    {{(PROD_W+2-bcx_pkg::RES_W){1'b1}}, {(bcx_pkg::RES_W-1){1'b0}}};

  // running state
  logic signed [ACC_BITS-1:0] acc_q;
  logic                       sat_q;

  // stage 1: closed accumulator of a finished output
  logic                               v1_q;
  logic signed [ACC_BITS-1:0]         acc1_q;
  logic                               sat1_q;
  logic signed [bcx_pkg::OFF_W-1:0]   off1_q;
  logic signed [bcx_pkg::SLOPE_W-1:0] slope1_q;

  // stage 2: sum with offset in q.8
  logic                               v2_q;
  logic signed [SUM_W-1:0]            sum2_q, sum2_d;
  logic                               sat2_q;
  logic signed [bcx_pkg::SLOPE_W-1:0] slope2_q;

  // stage 3: product in q.22
  logic                               v3_q;
  logic signed [PROD_W-1:0]           prod3_q, prod3_d;
  logic                               sat3_q;

  logic signed [ACC_BITS:0]           acc_sum;
  logic signed [ACC_BITS-1:0]         acc_new;
  logic                               ovf;
  logic                               en1, en2, en3;
  logic signed [bcx_pkg::SLOPE_W-1:0] factor;
  logic signed [PROD_W:0]             rnd_sum, rnd_q8;
  logic                               clamp;

  // stall chain from the result queue back to the work queue
  assign en3        = !v3_q || !res_full_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign work_pop_o = !work_empty_i && en1;
  assign res_push_o = v3_q && !res_full_i;

  // saturating accumulate
  always_comb begin
    acc_sum = (ACC_BITS+1)'(acc_q) + (ACC_BITS+1)'(work_i.contrib);
    ovf     = 1'b0;
    acc_new = acc_sum[ACC_BITS-1:0];
    if (acc_sum > ACC_MAX) begin
      acc_new = ACC_MAX[ACC_BITS-1:0];
      ovf     = 1'b1;
    end else if (acc_sum < ACC_MIN) begin
      acc_new = ACC_MIN[ACC_BITS-1:0];
      ovf     = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
      sat_q <= 1'b0;
    end else if (work_pop_o) begin
      if (work_i.last) begin
        acc_q <= '0;
        sat_q <= 1'b0;
      end else begin
        acc_q <= acc_new;
        sat_q <= sat_q || ovf;
      end
    end
  end

  assign sum2_d = $signed({{(SUM_W-ACC_BITS-bcx_pkg::Q_SH){acc1_q[ACC_BITS-1]}},
                           acc1_q, {bcx_pkg::Q_SH{1'b0}}})
                + $signed({{(SUM_W-bcx_pkg::OFF_W){off1_q[bcx_pkg::OFF_W-1]}}, off1_q});

  // a non-negative sum goes through at a slope of one
  assign factor  = sum2_q[SUM_W-1] ? slope2_q : bcx_pkg::UNIT_SLOPE;
  assign prod3_d = sum2_q * factor;

  // round half up to q.8 and clamp to the result range
  always_comb begin
    rnd_sum = (PROD_W+1)'(prod3_q) + ROUND_HALF;
    rnd_q8  = rnd_sum >>> bcx_pkg::ROUND_SH;
    clamp   = (rnd_q8 > RES_MAX) || (rnd_q8 < RES_MIN);
    res_o.value = rnd_q8[bcx_pkg::RES_W-1:0];
    if (rnd_q8 > RES_MAX) begin
      res_o.value = RES_MAX[bcx_pkg::RES_W-1:0];
    end else if (rnd_q8 < RES_MIN) begin
      res_o.value = RES_MIN[bcx_pkg::RES_W-1:0];
    end
    res_o.sat = sat3_q || clamp;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= work_pop_o && work_i.last;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
      if (en3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      acc1_q   <= acc_new;
      sat1_q   <= sat_q || ovf;
      off1_q   <= work_i.offset;
      slope1_q <= work_i.slope;
    end
    if (en2) begin
      sum2_q   <= sum2_d;
      sat2_q   <= sat1_q;
      slope2_q <= slope1_q;
    end
    if (en3) begin
      prod3_q <= prod3_d;
      sat3_q  <= sat2_q;
    end
  end

endmodule

### hdl/binary_conv_xnor_popcount_prelu.sv
// binarised convolution accumulator with fused batch-norm offset and prelu.
// each request carries one packed activation word and its weight word; the
// block adds valid_bits minus twice the popcount of their xor (low valid_bits
// bits only) to a saturating ACC_BITS accumulator. the request flagged
// last_word closes the output: the offset (q23.8) is added, a negative sum is
// scaled by the slope (q1.14) with round half up, the value is clamped to
// 32 bits and one result is queued, and the accumulator clears. other requests
// give no result. one request is taken every cycle while the work queue has
// room; that rate is set by the combinational popcount in the front and the
// accumulate loop in the back. after its last word is taken, a result passes
// the accumulate, offset add and multiply registers into the result queue.
// both sides look like queues: push/full in, empty/pop out.
module binary_conv_xnor_popcount_prelu #(
  parameter int WORD_BITS = 32,
  parameter int ACC_BITS  = 20
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // request side
  input  logic                               push,
  output logic                               full,
  input  logic [WORD_BITS-1:0]               act_word_i,
  input  logic [WORD_BITS-1:0]               weight_word_i,
  input  logic [bcx_pkg::VALID_W-1:0]        valid_bits_i,
  input  logic                               last_word_i,
  input  logic signed [bcx_pkg::OFF_W-1:0]   bn_offset_i,
  input  logic signed [bcx_pkg::SLOPE_W-1:0] prelu_slope_i,
  // result side
  output logic                               empty,
  input  logic                               pop,
  output logic signed [bcx_pkg::RES_W-1:0]   result_value_o,
  output logic                               saturated_o
);

  localparam int QUEUE_DEPTH = 2;

  // front to back: classified words
  logic             work_push, work_full, work_pop, work_empty;
  bcx_pkg::work_t   work_wdata, work_rdata;

  // back to output: finished results
  logic             res_push, res_full;
  bcx_pkg::result_t res_wdata, res_rdata;

  assign full = work_full;

  // front: masks the word, counts mismatches, forms the signed contribution
  bcx_front #(
    .WORD_BITS (WORD_BITS)
  ) u_front (
    .push_i        (push),
    .act_word_i    (act_word_i),
    .weight_word_i (weight_word_i),
    .valid_bits_i  (valid_bits_i),
    .last_word_i   (last_word_i),
    .bn_offset_i   (bn_offset_i),
    .prelu_slope_i (prelu_slope_i),
    .work_full_i   (work_full),
    .work_push_o   (work_push),
    .work_o        (work_wdata)
  );

  // short queue so the front can still take requests while the back stalls, until the queue fills
  bcx_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W ($bits(bcx_pkg::work_t))
  ) u_work_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (work_push),
    .wdata_i (work_wdata),
    .full_o  (work_full),
    .pop_i   (work_pop),
    .rdata_o (work_rdata),
    .empty_o (work_empty)
  );

  // back: accumulate, then offset, prelu, rounding and clamp on the last word
  bcx_back #(
    .ACC_BITS (ACC_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .work_i       (work_rdata),
    .work_empty_i (work_empty),
    .work_pop_o   (work_pop),
    .res_full_i   (res_full),
    .res_push_o   (res_push),
    .res_o        (res_wdata)
  );

  // result queue doubles as the output register
  bcx_queue #(
    .DEPTH  (QUEUE_DEPTH),
    .DATA_W ($bits(bcx_pkg::result_t))
  ) u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .empty_o (empty)
  );

  assign result_value_o = res_rdata.value;
  assign saturated_o    = res_rdata.sat;

`ifndef SYNTHESIS
  // the front never writes a full work queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) work_push |-> !work_full)
    else $error("work queue written while full");

  // the back only takes words that are there
  assert property (@(posedge clk_i) disable iff (!rst_ni) work_pop |-> !work_empty)
    else $error("work queue read while empty");

  // a finished result is never pushed into a full result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_push |-> !res_full)
    else $error("result queue written while full");

  // a result cannot appear without a push into the result queue
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (empty && !res_push) |=> empty)
    else $error("result appeared without a push");
`endif

endmodule
